// ===== rtl/matrix_inverse_3x3_macros.svh =====
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

    localparam int FIELD_BITS = 32;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] m_00;
        logic signed [FIELD_BITS-1:0] m_01;
        logic signed [FIELD_BITS-1:0] m_02;
        logic signed [FIELD_BITS-1:0] m_10;
        logic signed [FIELD_BITS-1:0] m_11;
        logic signed [FIELD_BITS-1:0] m_12;
        logic signed [FIELD_BITS-1:0] m_20;
        logic signed [FIELD_BITS-1:0] m_21;
        logic signed [FIELD_BITS-1:0] m_22;
    } mat_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] inv_00;
        logic signed [FIELD_BITS-1:0] inv_01;
        logic signed [FIELD_BITS-1:0] inv_02;
        logic signed [FIELD_BITS-1:0] inv_10;
        logic signed [FIELD_BITS-1:0] inv_11;
        logic signed [FIELD_BITS-1:0] inv_12;
        logic signed [FIELD_BITS-1:0] inv_20;
        logic signed [FIELD_BITS-1:0] inv_21;
        logic signed [FIELD_BITS-1:0] inv_22;
        logic                         singular;
    } inv_t;

endpackage

// ===== rtl/mi3_stream_if.sv =====
interface mi3_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mi3_cofactor.sv =====
module mi3_cofactor #(
    parameter int W  = 32,
    parameter int CW = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic signed [W-1:0]  elem [9],
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic signed [W-1:0]  row0 [3],
    output logic signed [CW-1:0] cof [9]
);
    localparam int NS = 2;
    localparam int PW = 2 * W;

    logic [NS-1:0]       v_reg;
    logic [NS-1:0]       en;
    logic signed [2*W-1:0] pa_next [9];
    logic signed [2*W-1:0] pb_next [9];
    logic signed [2*W-1:0] pa_reg [9];
    logic signed [2*W-1:0] pb_reg [9];
    logic signed [W-1:0]   row_reg [2][3];
    logic signed [CW-1:0]  cof_reg [9];

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || dn_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign up_ready = en[0];
    assign dn_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // adj[r][c] is the cofactor of m[c][r]
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pa_next[r*3+c] = PW'(elem[((c+1)%3)*3 + (r+1)%3])
                               * PW'(elem[((c+2)%3)*3 + (r+2)%3]);
                pb_next[r*3+c] = PW'(elem[((c+2)%3)*3 + (r+1)%3])
                               * PW'(elem[((c+1)%3)*3 + (r+2)%3]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            row_reg[0] <= elem[0:2];
        end
        if (en[1])
        begin
            for (int k = 0; k < 9; k++)
            begin
                cof_reg[k] <= CW'(pa_reg[k]) - CW'(pb_reg[k]);
            end
            row_reg[1] <= row_reg[0];
        end
    end

    assign row0 = row_reg[1];
    assign cof  = cof_reg;
endmodule

// ===== rtl/mi3_det.sv =====
module mi3_det #(
    parameter int W  = 32,
    parameter int CW = 64,
    parameter int DW = 97
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic signed [W-1:0]  row0 [3],
    input  logic signed [CW-1:0] cof [9],
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [DW-1:0]        dmag,
    output logic                 dzero,
    output logic [CW-1:0]        cmag [9],
    output logic                 sneg [9]
);
    localparam int NS = 4;
    localparam int H  = CW / 2;
    localparam int LW = W + H + 1;
    localparam int HW = W + CW - H;

    logic [NS-1:0]              v_reg;
    logic [NS-1:0]              en;
    logic signed [W+H:0]        plo_reg [3];
    logic signed [W+CW-H-1:0]   phi_reg [3];
    logic signed [DW-1:0]       term_reg [3];
    logic signed [DW-1:0]       det_reg;
    logic signed [CW-1:0]       cof_reg [3][9];
    logic [DW-1:0]              dmag_reg;
    logic                       dzero_reg;
    logic [CW-1:0]              cmag_reg [9];
    logic                       sneg_reg [9];

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || dn_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign up_ready = en[0];
    assign dn_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // split the cofactor of each row-0 element into a signed high half and an unsigned low half
        if (en[0])
        begin
            for (int c = 0; c < 3; c++)
            begin
                plo_reg[c] <= LW'(row0[c]) * LW'($signed({1'b0, cof[c*3][H-1:0]}));
                phi_reg[c] <= HW'(row0[c]) * HW'($signed(cof[c*3][CW-1:H]));
            end
            cof_reg[0] <= cof;
        end
        if (en[1])
        begin
            for (int c = 0; c < 3; c++)
            begin
                term_reg[c] <= (DW'(phi_reg[c]) <<< H) + DW'(plo_reg[c]);
            end
            cof_reg[1] <= cof_reg[0];
        end
        if (en[2])
        begin
            det_reg    <= term_reg[0] + term_reg[1] + term_reg[2];
            cof_reg[2] <= cof_reg[1];
        end
        if (en[3])
        begin
            dzero_reg <= (det_reg == '0);
            dmag_reg  <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            for (int k = 0; k < 9; k++)
            begin
                cmag_reg[k] <= cof_reg[2][k][CW-1] ? CW'(-cof_reg[2][k]) : CW'(cof_reg[2][k]);
                sneg_reg[k] <= cof_reg[2][k][CW-1] ^ det_reg[DW-1];
            end
        end
    end

    assign dmag  = dmag_reg;
    assign dzero = dzero_reg;
    assign cmag  = cmag_reg;
    assign sneg  = sneg_reg;
endmodule

// ===== rtl/mi3_divide.sv =====
module mi3_divide #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int CW = 64,
    parameter int DW = 97
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [DW-1:0]        dmag,
    input  logic                 dzero,
    input  logic [CW-1:0]        cmag [9],
    input  logic                 sneg [9],
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output mi3_pkg::inv_t        dn_data
);
    import mi3_pkg::*;

    localparam int NS = W + 2;
    localparam int NW = CW + 2 * F;
    localparam int RW = (NW > DW + W) ? NW : DW + W;
    localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] POS_LIM = ~NEG_LIM;

    logic [NS-1:0]  v_reg;
    logic [NS-1:0]  en;
    logic [RW-1:0]  rem_reg [W+1][9];
    logic [W-1:0]   q_reg [W+1][9];
    logic           ovf_reg [W+1][9];
    logic           neg_reg [W+1][9];
    logic [DW-1:0]  d_reg [W+1];
    logic           zero_reg [W+1];
    logic [W-1:0]   val [9];
    inv_t           out_next;
    inv_t           out_reg;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || dn_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign up_ready = en[0];
    assign dn_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // a quotient of 2^W or more saturates for either sign
    always_ff @(posedge clk)
    begin
        logic [RW-1:0] lim;
        logic [RW-1:0] num;
        lim = RW'(dmag) << W;
        if (en[0])
        begin
            for (int k = 0; k < 9; k++)
            begin
                num = RW'(cmag[k]) << (2 * F);
                rem_reg[0][k] <= num;
                ovf_reg[0][k] <= (num >= lim);
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= sneg[k];
            end
            d_reg[0]    <= dmag;
            zero_reg[0] <= dzero;
        end
    end

    for (genvar s = 1; s <= W; s++)
    begin : g_step
        localparam int B = W - s;

        always_ff @(posedge clk)
        begin
            logic [RW-1:0] sub;
            logic [W-1:0]  q;
            sub = RW'(d_reg[s-1]) << B;
            if (en[s])
            begin
                for (int k = 0; k < 9; k++)
                begin
                    q = q_reg[s-1][k];
                    if (rem_reg[s-1][k] >= sub)
                    begin
                        rem_reg[s][k] <= rem_reg[s-1][k] - sub;
                        q[B] = 1'b1;
                    end
                    else
                    begin
                        rem_reg[s][k] <= rem_reg[s-1][k];
                    end
                    q_reg[s][k]   <= q;
                    ovf_reg[s][k] <= ovf_reg[s-1][k];
                    neg_reg[s][k] <= neg_reg[s-1][k];
                end
                d_reg[s]    <= d_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    always_comb
    begin
        logic [W-1:0] mag;
        for (int k = 0; k < 9; k++)
        begin
            mag = '0;
            if (zero_reg[W])
            begin
                val[k] = '0;
            end
            else if (neg_reg[W][k])
            begin
                mag    = (ovf_reg[W][k] || q_reg[W][k] > NEG_LIM) ? NEG_LIM : q_reg[W][k];
                val[k] = -mag;
            end
            else
            begin
                val[k] = (ovf_reg[W][k] || q_reg[W][k] > POS_LIM) ? POS_LIM : q_reg[W][k];
            end
        end
        out_next.inv_00   = FIELD_BITS'(val[0]);
        out_next.inv_01   = FIELD_BITS'(val[1]);
        out_next.inv_02   = FIELD_BITS'(val[2]);
        out_next.inv_10   = FIELD_BITS'(val[3]);
        out_next.inv_11   = FIELD_BITS'(val[4]);
        out_next.inv_12   = FIELD_BITS'(val[5]);
        out_next.inv_20   = FIELD_BITS'(val[6]);
        out_next.inv_21   = FIELD_BITS'(val[7]);
        out_next.inv_22   = FIELD_BITS'(val[8]);
        out_next.singular = zero_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            out_reg <= out_next;
        end
    end

    assign dn_data = out_reg;
endmodule

// ===== rtl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by adjugate, signed fixed point.
// Input channel mat carries one matrix per item (m_00 .. m_22, two's complement
// in ELEM_WIDTH bits with FRAC_BITS fraction bits; higher bits are ignored).
// Output channel inv carries one result per item: inv_00 .. inv_22 in the same
// format, truncated toward zero and saturated, upper bits zero, plus singular,
// which is set with all elements zero when the determinant is zero.
// Both channels move an item when valid and ready are high at a clock edge.
// Items pass through the product and cofactor stages, the determinant stages,
// a divide setup stage, a step per quotient bit in nine parallel restoring
// dividers, and the output register.
// Throughput is one item per cycle while inv is ready; the divider lanes set the depth.
// A stall on inv holds the output register; each stage keeps loading while it
// has a bubble, so mat stays ready until the pipeline is completely full.
// Reset clears only the stage valid bits; nothing is in flight afterwards.
module matrix_inverse_3x3 #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    mi3_stream_if.sink   mat,
    mi3_stream_if.source inv
);
    import mi3_pkg::*;

    `include "matrix_inverse_3x3_macros.svh"

    localparam int W  = ELEM_WIDTH;
    localparam int CW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int DW = W + CW + 1;

    logic signed [W-1:0]  elem [9];
    logic                 cof_valid;
    logic                 cof_ready;
    logic signed [W-1:0]  row0 [3];
    logic signed [CW-1:0] cof [9];
    logic                 det_valid;
    logic                 det_ready;
    logic [DW-1:0]        dmag;
    logic                 dzero;
    logic [CW-1:0]        cmag [9];
    logic                 sneg [9];

    assign elem[0] = $signed(mat.data.m_00[W-1:0]);
    assign elem[1] = $signed(mat.data.m_01[W-1:0]);
    assign elem[2] = $signed(mat.data.m_02[W-1:0]);
    assign elem[3] = $signed(mat.data.m_10[W-1:0]);
    assign elem[4] = $signed(mat.data.m_11[W-1:0]);
    assign elem[5] = $signed(mat.data.m_12[W-1:0]);
    assign elem[6] = $signed(mat.data.m_20[W-1:0]);
    assign elem[7] = $signed(mat.data.m_21[W-1:0]);
    assign elem[8] = $signed(mat.data.m_22[W-1:0]);

    mi3_cofactor #(.W(W), .CW(CW)) u_cofactor (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mat.valid),
        .up_ready (mat.ready),
        .elem     (elem),
        .dn_valid (cof_valid),
        .dn_ready (cof_ready),
        .row0     (row0),
        .cof      (cof)
    );

    mi3_det #(.W(W), .CW(CW), .DW(DW)) u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cof_valid),
        .up_ready (cof_ready),
        .row0     (row0),
        .cof      (cof),
        .dn_valid (det_valid),
        .dn_ready (det_ready),
        .dmag     (dmag),
        .dzero    (dzero),
        .cmag     (cmag),
        .sneg     (sneg)
    );

    mi3_divide #(.W(W), .F(FRAC_BITS), .CW(CW), .DW(DW)) u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (det_valid),
        .up_ready (det_ready),
        .dmag     (dmag),
        .dzero    (dzero),
        .cmag     (cmag),
        .sneg     (sneg),
        .dn_valid (inv.valid),
        .dn_ready (inv.ready),
        .dn_data  (inv.data)
    );

    `MI3_ASSERT_NOW(a_singular_zero, inv.valid && inv.data.singular, inv.data.inv_00 == 0 && inv.data.inv_11 == 0 && inv.data.inv_22 == 0 && inv.data.inv_01 == 0 && inv.data.inv_12 == 0, "singular result with nonzero element")
    `MI3_ASSERT_NOW(a_upper_clear, inv.valid, (inv.data.inv_00 >> ELEM_WIDTH) == 0, "bits above element width set")
    `MI3_ASSERT_NOW(a_full_stall, !mat.ready, cof_valid, "input stalled while cofactor stage is empty")
    `MI3_ASSERT_NEXT(a_det_hold, det_valid && !det_ready, det_valid, "determinant item dropped under stall")
endmodule
